### src/msk_pkg.sv
// Shared types, codes and defaults for the min stack engine.
`default_nettype none

package msk_pkg;

  localparam int unsigned DefaultDepth = 1024;

  localparam int unsigned WordW   = 32;
  localparam int unsigned FuncW   = 3;
  localparam int unsigned StatusW = 2;

  localparam logic [FuncW-1:0] FuncPush  = 3'd0;
  localparam logic [FuncW-1:0] FuncPop   = 3'd1;
  localparam logic [FuncW-1:0] FuncBack  = 3'd2;
  localparam logic [FuncW-1:0] FuncClear = 3'd3;
  localparam logic [FuncW-1:0] FuncMin   = 3'd4;
  localparam logic [FuncW-1:0] FuncSize  = 3'd5;

  localparam logic [StatusW-1:0] StatusOk  = 2'd0;
  localparam logic [StatusW-1:0] StatusVal = 2'd1;
  localparam logic [StatusW-1:0] StatusErr = 2'd2;

  // One stack level: the word and the minimum of it and everything below it.
  typedef struct packed {
    logic signed [WordW-1:0] data;
    logic signed [WordW-1:0] min;
  } entry_t;

  // Shift control broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

`default_nettype wire

### src/msk_cell.sv
// One stack level cell that shifts down on push and up on pop.
`default_nettype none

module msk_cell
  import msk_pkg::*;
(
  input  wire logic   clk_i,
  input  wire shift_t ctl_i,
  input  wire entry_t above_i,
  input  wire entry_t below_i,
  output entry_t      entry_o
);

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.push) begin
      entry_d = above_i;
    end else if (ctl_i.pop) begin
      entry_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

### src/min_stack_engine.sv
// Top level of the min stack engine: command decode, cell chain and response register.
// A response is registered and presented in the cycle after its command beat is accepted.
// Throughput: one command per cycle; push and pop shift every cell of the chain, other commands only read the top cell.
// A stalled response holds the input side until the response beat is taken.
// Reset clears the fill count and the response valid; cell contents stay undefined.
`default_nettype none

module min_stack_engine
  import msk_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [2:0] func, [34:3] push_value, [39:35] zero
  input  wire logic [39:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [1:0] status, [33:2] value, [39:34] zero
  output logic [39:0]      m_axis_tdata_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [FuncW-1:0]        func;
  logic signed [WordW-1:0] push_value;
  logic                    accept;
  logic                    empty, full;

  logic [CntW-1:0]         fill_q, fill_d;
  logic                    out_valid_q;
  logic [StatusW-1:0]      status_q, status_d;
  logic signed [WordW-1:0] value_q, value_d;

  shift_t                  ctl;
  entry_t                  new_entry;
  entry_t                  cells [DEPTH];

  assign func       = s_axis_tdata_i[2:0];
  assign push_value = $signed(s_axis_tdata_i[34:3]);
  assign accept     = s_axis_tvalid_i & s_axis_tready_o;
  assign empty      = (fill_q == '0);
  assign full       = (fill_q == CntW'(DEPTH));

  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;

  always_comb begin
    new_entry.data = push_value;
    if (empty || (push_value < cells[0].min)) begin
      new_entry.min = push_value;
    end else begin
      new_entry.min = cells[0].min;
    end
  end

  always_comb begin
    ctl      = '0;
    fill_d   = fill_q;
    status_d = StatusErr;
    value_d  = '0;
    unique case (func)
      FuncPush: begin
        if (!full) begin
          ctl.push = accept;
          fill_d   = fill_q + 1'b1;
          status_d = StatusOk;
        end
      end
      FuncPop: begin
        if (!empty) begin
          ctl.pop  = accept;
          fill_d   = fill_q - 1'b1;
          status_d = StatusVal;
          value_d  = cells[0].data;
        end
      end
      FuncBack: begin
        if (!empty) begin
          status_d = StatusVal;
          value_d  = cells[0].data;
        end
      end
      FuncClear: begin
        fill_d   = '0;
        status_d = StatusOk;
      end
      FuncMin: begin
        if (!empty) begin
          status_d = StatusVal;
          value_d  = cells[0].min;
        end
      end
      FuncSize: begin
        status_d = StatusVal;
        value_d  = $signed({{(WordW - CntW){1'b0}}, fill_q});
      end
      default: begin
        status_d = StatusErr;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q <= fill_d;
      end
      if (s_axis_tready_o) begin
        out_valid_q <= s_axis_tvalid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      value_q  <= value_d;
    end
  end

  // Cell 0 is the top of the stack; the bottom cell refills from itself on pop.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t above, below;
    if (i == 0) begin : g_top
      assign above = new_entry;
    end else begin : g_mid
      assign above = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign below = cells[i];
    end else begin : g_up
      assign below = cells[i+1];
    end
    msk_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .above_i (above),
      .below_i (below),
      .entry_o (cells[i])
    );
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, value_q, status_q};

`ifndef ASSERT_OFF
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(DEPTH))
    else $error("fill count exceeds depth");

  a_push_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func == FuncPush && !full) |=> (cells[0].data == $past(push_value)))
    else $error("pushed word not at top of chain");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func == FuncPop && !empty) |=> (fill_q == $past(fill_q) - 1'b1))
    else $error("pop did not decrement fill count");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != StatusVal) |-> (value_q == '0))
    else $error("non-value response carries a nonzero value");
`endif

endmodule

`default_nettype wire

### bench/msk_checker.sv
// Checker for the min stack engine: tracks the stack, predicts each answer and compares it.
module msk_checker
  import msk_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  wire logic        cmd_ready_i,
  // [2:0] func, [34:3] push_value, [39:35] zero
  input  wire logic [39:0] cmd_data_i,
  input  wire logic        rsp_valid_i,
  input  wire logic        rsp_ready_i,
  // [1:0] status, [33:2] value, [39:34] zero
  input  wire logic [39:0] rsp_data_i,
  output int unsigned      mismatches_o,
  output int unsigned      pending_o
);

  typedef struct packed {
    logic [StatusW-1:0]      status;
    logic signed [WordW-1:0] value;
  } answer_t;

  logic signed [WordW-1:0] word_mem [DEPTH];
  logic signed [WordW-1:0] min_mem  [DEPTH];
  int unsigned             level = 0;
  answer_t                 answer_q [$];
  int unsigned             mismatch_cnt = 0;
  int unsigned             pending_cnt = 0;

  assign mismatches_o = mismatch_cnt;
  assign pending_o    = pending_cnt;

  // Applies one command to the shadow stack and returns the answer the block owes for it.
  function automatic answer_t apply_cmd(logic [FuncW-1:0] func, logic signed [WordW-1:0] word);
    answer_t ans;
    ans.status = StatusErr;
    ans.value  = '0;
    case (func)
      FuncPush: begin
        if (level < DEPTH) begin
          if (level == 0) begin
            min_mem[0] = word;
          end else if (word < min_mem[level-1]) begin
            min_mem[level] = word;
          end else begin
            min_mem[level] = min_mem[level-1];
          end
          word_mem[level] = word;
          level++;
          ans.status = StatusOk;
        end
      end
      FuncPop: begin
        if (level > 0) begin
          level--;
          ans.status = StatusVal;
          ans.value  = word_mem[level];
        end
      end
      FuncBack: begin
        if (level > 0) begin
          ans.status = StatusVal;
          ans.value  = word_mem[level-1];
        end
      end
      FuncClear: begin
        level      = 0;
        ans.status = StatusOk;
      end
      FuncMin: begin
        if (level > 0) begin
          ans.status = StatusVal;
          ans.value  = min_mem[level-1];
        end
      end
      FuncSize: begin
        ans.status = StatusVal;
        ans.value  = WordW'(level);
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: %s", $time, what);
    mismatch_cnt++;
  endtask

  // The response beat taken at an edge always belongs to an earlier command, so it is
  // checked before the command beat of the same edge is predicted.
  always @(posedge clk_i) begin
    answer_t got;
    answer_t want;
    if (!rst_ni) begin
      level = 0;
      answer_q.delete();
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        got.status = rsp_data_i[1:0];
        got.value  = rsp_data_i[33:2];
        if (answer_q.size() == 0) begin
          report_mismatch($sformatf("response beat with no command outstanding: status %0d value %0d",
                                    got.status, got.value));
        end else begin
          want = answer_q.pop_front();
          if (got.status != want.status) begin
            report_mismatch($sformatf("status expected %0d, got %0d", want.status, got.status));
          end
          if (got.value != want.value) begin
            report_mismatch($sformatf("value expected %0d, got %0d", want.value, got.value));
          end
        end
      end
      if (cmd_valid_i && cmd_ready_i) begin
        answer_q.push_back(apply_cmd(cmd_data_i[2:0], cmd_data_i[34:3]));
      end
    end
    pending_cnt = answer_q.size();
  end

endmodule

### bench/tb_min_stack_engine.sv
// Testbench top for the min stack engine: clock, reset, command stimulus, response pacing and verdict.
module tb_min_stack_engine;
  import msk_pkg::*;

  localparam int unsigned StackDepth    = DefaultDepth;
  localparam int unsigned RandItems     = 90;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 8;

  // Function codes the block does not implement.
  localparam logic [FuncW-1:0] FuncBadLow  = 3'd6;
  localparam logic [FuncW-1:0] FuncBadHigh = 3'd7;

  typedef enum int unsigned {RdyAlways, RdyCoin, RdySparse} rdy_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cmd_valid = 1'b0;
  logic [39:0] cmd_data = '0;
  logic        rsp_ready = 1'b0;
  wire         cmd_ready;
  wire         rsp_valid;
  wire  [39:0] rsp_data;

  int unsigned mismatches;
  int unsigned pending;
  bit          hold_req = 1'b0;
  int unsigned burst_left = 0;
  int unsigned level_guess = 0;

  initial forever #4 clk = ~clk;

  min_stack_engine #(
    .DEPTH(StackDepth)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(cmd_valid),
    .s_axis_tready_o(cmd_ready),
    .s_axis_tdata_i (cmd_data),
    .m_axis_tvalid_o(rsp_valid),
    .m_axis_tready_i(rsp_ready),
    .m_axis_tdata_o (rsp_data)
  );

  msk_checker #(
    .DEPTH(StackDepth)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_data_i  (cmd_data),
    .rsp_valid_i (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_data_i  (rsp_data),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  function automatic logic signed [WordW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(WordW-1){1'b1}}};
      1:       return {1'b1, {(WordW-1){1'b0}}};
      2, 3, 4: return $signed($urandom_range(0, 16)) - 32'sd8;
      default: return $urandom();
    endcase
  endfunction

  // Sends one command beat; between bursts the valid line drops for a random gap.
  task automatic issue_cmd(input logic [FuncW-1:0] func, input logic signed [WordW-1:0] word);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      cmd_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 30);
    end
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd_data  <= {5'b0, word, func};
    do @(posedge clk); while (!cmd_ready);
    burst_left--;
    case (func)
      FuncPush:  if (level_guess < StackDepth) level_guess++;
      FuncPop:   if (level_guess > 0) level_guess--;
      FuncClear: level_guess = 0;
      default: begin
      end
    endcase
  endtask

  // Pushes until the stack is full, then probes the full case and unwinds a little.
  task automatic fill_to_capacity();
    issue_cmd(FuncClear, '0);
    while (level_guess < StackDepth) issue_cmd(FuncPush, pick_word());
    issue_cmd(FuncPush, pick_word());
    issue_cmd(FuncPush, {1'b1, {(WordW-1){1'b0}}});
    issue_cmd(FuncSize, '0);
    issue_cmd(FuncMin, '0);
    issue_cmd(FuncBack, '0);
    repeat (5) issue_cmd(FuncPop, '0);
    issue_cmd(FuncMin, '0);
    issue_cmd(FuncPush, pick_word());
    issue_cmd(FuncSize, '0);
    issue_cmd(FuncClear, '0);
  endtask

  // Response side: random pacing modes, plus one long hold-off on request.
  initial begin
    int unsigned phase_cnt;
    rdy_mode_e   mode;
    phase_cnt = 0;
    mode      = RdyAlways;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rsp_ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (phase_cnt == 0) begin
          mode      = rdy_mode_e'($urandom_range(0, 2));
          phase_cnt = $urandom_range(16, 96);
        end
        phase_cnt--;
        case (mode)
          RdyAlways: rsp_ready <= 1'b1;
          RdyCoin:   rsp_ready <= $urandom_range(0, 1);
          default:   rsp_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Ends the run when no beat moves on either side for too long.
  initial begin
    int unsigned idle_cnt;
    idle_cnt = 0;
    forever begin
      @(posedge clk);
      if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= WatchdogLimit) break;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned      r;
    int unsigned      target;
    logic [FuncW-1:0] func;
    target = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty stack, extremes, ties in the minimum and the unused codes.
    issue_cmd(FuncPop, '0);
    issue_cmd(FuncBack, '0);
    issue_cmd(FuncMin, '0);
    issue_cmd(FuncSize, '0);
    issue_cmd(FuncPush, {1'b0, {(WordW-1){1'b1}}});
    issue_cmd(FuncMin, '0);
    issue_cmd(FuncPush, {1'b1, {(WordW-1){1'b0}}});
    issue_cmd(FuncMin, '0);
    issue_cmd(FuncPush, -32'sd1);
    issue_cmd(FuncBack, '0);
    issue_cmd(FuncMin, '0);
    issue_cmd(FuncSize, '0);
    issue_cmd(FuncPush, '0);
    issue_cmd(FuncBadLow, $urandom());
    issue_cmd(FuncBadHigh, $urandom());
    issue_cmd(FuncPop, '0);
    issue_cmd(FuncPop, '0);
    issue_cmd(FuncMin, '0);
    issue_cmd(FuncPop, '0);
    issue_cmd(FuncPop, '0);
    issue_cmd(FuncPush, 32'sd5);
    issue_cmd(FuncPush, 32'sd5);
    issue_cmd(FuncClear, '0);
    issue_cmd(FuncSize, '0);
    issue_cmd(FuncBack, '0);

    fill_to_capacity();

    // The stack grows toward a moving target depth and shrinks once it has reached it.
    for (int unsigned n = 0; n < RandItems; n++) begin
      if (n % 60 == 0) begin
        target = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 24);
      end
      if (n == RandItems / 3) hold_req = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 2)       func = $urandom_range(0, 1) ? FuncBadLow : FuncBadHigh;
      else if (r < 4)  func = FuncClear;
      else if (r < 12) func = FuncSize;
      else if (r < 24) func = FuncMin;
      else if (r < 34) func = FuncBack;
      else if (level_guess < target) func = (r < 80) ? FuncPush : FuncPop;
      else func = (r < 50) ? FuncPush : FuncPop;
      issue_cmd(func, ($urandom_range(0, 3) == 0) ? $urandom() : pick_word());
    end

    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
